// ===== hdl/mprc_pkg.sv =====
`default_nettype none
package mprc_pkg;

  // Tree geometry: leaves at level 0, the root at the top level.
  localparam int unsigned POSITIONS = 1024;
  localparam int unsigned IDX_W     = $clog2(POSITIONS);
  localparam int unsigned LEVELS    = IDX_W + 1;
  localparam int unsigned LVL_W     = $clog2(LEVELS);
  localparam int unsigned POS_W     = 11;
  localparam int unsigned CNT_W     = 11;

  // Request kinds on the input channel.
  localparam logic REQ_MARK  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register index of the size register.
  localparam logic REG_SIZE = 1'b0;

  // One request as it travels up the row of level cells.
  typedef struct packed {
    logic             active;
    logic             is_mark;
    logic             ok;
    logic             fresh;
    logic [POS_W-1:0] p_hi;
    logic [POS_W-1:0] p_lo;
    logic [CNT_W-1:0] sum_hi;
    logic [CNT_W-1:0] sum_lo;
  } tok_t;

endpackage
`default_nettype wire

// ===== hdl/mprc_cell.sv =====
`default_nettype none
module mprc_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [mprc_pkg::LVL_W-1:0] level,
  input  wire logic                       clr_en,
  input  wire logic [mprc_pkg::IDX_W-1:0] clr_addr,
  input  wire mprc_pkg::tok_t             tok_in,
  output mprc_pkg::tok_t                  tok_out
);

  logic [mprc_pkg::CNT_W-1:0] cnt_mem [mprc_pkg::POSITIONS];

  mprc_pkg::tok_t             tok_r, out_r, out_nxt;
  logic [mprc_pkg::CNT_W-1:0] rdh_r, rdl_r;
  logic [mprc_pkg::IDX_W-1:0] wa_r;
  logic [mprc_pkg::POS_W-1:0] sh_hi, sh_lo, sh_hi_m1, sh_lo_m1;
  logic [mprc_pkg::IDX_W-1:0] idx_hi, idx_lo;
  logic                       new_c;

  // Node addresses at this level. A mark walks the leaf's ancestors; a
  // prefix count takes the node just left of the shifted prefix length.
  always_comb begin
    sh_hi    = tok_in.p_hi >> level;
    sh_lo    = tok_in.p_lo >> level;
    sh_hi_m1 = sh_hi - mprc_pkg::POS_W'(1);
    sh_lo_m1 = sh_lo - mprc_pkg::POS_W'(1);
    idx_hi   = tok_in.is_mark ? sh_lo[mprc_pkg::IDX_W-1:0] : sh_hi_m1[mprc_pkg::IDX_W-1:0];
    idx_lo   = sh_lo_m1[mprc_pkg::IDX_W-1:0];
  end

  // Registered reads of this level's counts.
  always_ff @(posedge clk) begin
    rdh_r <= cnt_mem[idx_hi];
    rdl_r <= cnt_mem[idx_lo];
    wa_r  <= idx_hi;
  end

  // The leaf level decides whether a mark is new; upper levels follow it.
  assign new_c = (level == '0) ? (rdh_r == '0) : tok_r.fresh;

  // Count update for a new mark, or zeroing during a clearing pass.
  always_ff @(posedge clk) begin
    if (clr_en) begin
      cnt_mem[clr_addr] <= '0;
    end else if (tok_r.active && tok_r.is_mark && tok_r.ok && new_c) begin
      cnt_mem[wa_r] <= rdh_r + mprc_pkg::CNT_W'(1);
    end
  end

  // Accumulate both prefix sums and hand the request to the next level.
  always_comb begin
    out_nxt       = tok_r;
    out_nxt.fresh = new_c;
    if (!tok_r.is_mark && tok_r.ok) begin
      if (tok_r.p_hi[level]) begin
        out_nxt.sum_hi = tok_r.sum_hi + rdh_r;
      end
      if (tok_r.p_lo[level]) begin
        out_nxt.sum_lo = tok_r.sum_lo + rdl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
      out_r.active <= 1'b0;
    end else begin
      tok_r.active <= tok_in.active;
      out_r.active <= tok_r.active;
    end
    tok_r.is_mark <= tok_in.is_mark;
    tok_r.ok      <= tok_in.ok;
    tok_r.fresh   <= tok_in.fresh;
    tok_r.p_hi    <= tok_in.p_hi;
    tok_r.p_lo    <= tok_in.p_lo;
    tok_r.sum_hi  <= tok_in.sum_hi;
    tok_r.sum_lo  <= tok_in.sum_lo;
    out_r.is_mark <= out_nxt.is_mark;
    out_r.ok      <= out_nxt.ok;
    out_r.fresh   <= out_nxt.fresh;
    out_r.p_hi    <= out_nxt.p_hi;
    out_r.p_lo    <= out_nxt.p_lo;
    out_r.sum_hi  <= out_nxt.sum_hi;
    out_r.sum_lo  <= out_nxt.sum_lo;
  end

  assign tok_out = out_r;

endmodule
`default_nettype wire

// ===== hdl/marked_position_range_counter.sv =====
`default_nettype none
// Marked position range counter: a count tree over up to 1024 slots.
// Input channel in_*: tuser carries the request kind (0 mark, 1 range
// query); tdata carries the first and last positions. A mark sets one slot;
// a query returns the number of marked slots in [first, last] on out_*,
// with tuser set when the range is reversed or outside the size in use.
// Each request passes a launch register, then climbs a row of eleven level
// cells, each with a registered read and then an update, then a hold
// register and the output register. The next request is taken only once
// the previous one has left the hold register.
// One request is in flight at a time; the rate is set by the tree depth and the receiver.
// A finished result waits in an output register; while it waits the next
// request is still accepted and climbs the tree, and it holds at the top
// of the row until the receiver takes the earlier result.
// Reset, and every write of the size register over cfg_*, starts a
// clearing pass that zeroes all 1024 counts of every level; no request is
// accepted during it, but register writes are still taken.
module marked_position_range_counter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // first_pos[10:0], last_pos[21:11], zeros
  input  wire logic [0:0]  in_tuser,   // req_type[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // marked_count[10:0], zeros
  output logic [0:0]       out_tuser,  // range_error[0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned PW = mprc_pkg::POS_W;
  localparam int unsigned CW = mprc_pkg::CNT_W;
  localparam int unsigned NL = mprc_pkg::LEVELS;

  logic [PW-1:0]              size_r;
  logic                       clr_r;
  logic [mprc_pkg::IDX_W-1:0] clr_cnt_r;
  logic                       busy_r;
  mprc_pkg::tok_t             launch_r, launch_nxt;
  mprc_pkg::tok_t             done_r;
  logic                       out_valid_r;
  logic [CW-1:0]              out_cnt_r;
  logic                       out_err_r;
  mprc_pkg::tok_t             chain [NL+1];

  logic          cfg_wr;
  logic          in_acc;
  logic [PW-1:0] eff_size, first_pos, last_pos;
  logic          release_c;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == mprc_pkg::REG_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == mprc_pkg::REG_SIZE) ? {21'd0, size_r} : '0;

  // Size register and the clearing pass it triggers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= PW'(mprc_pkg::POSITIONS);
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (cfg_wr) begin
      size_r    <= cfg_pwdata[PW-1:0];
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + mprc_pkg::IDX_W'(1);
      if (clr_cnt_r == '1) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Effective size, clamped to between one and the tree size.
  always_comb begin
    eff_size = size_r;
    if (size_r == '0) begin
      eff_size = PW'(1);
    end else if (size_r > PW'(mprc_pkg::POSITIONS)) begin
      eff_size = PW'(mprc_pkg::POSITIONS);
    end
  end

  assign first_pos = in_tdata[PW-1:0];
  assign last_pos  = in_tdata[2*PW-1:PW];
  assign in_tready = !busy_r && !clr_r;
  assign in_acc    = in_tvalid && in_tready;

  // Build the request for the row of level cells.
  always_comb begin
    launch_nxt         = '0;
    launch_nxt.active  = in_acc;
    launch_nxt.is_mark = (in_tuser[0] == mprc_pkg::REQ_MARK);
    if (launch_nxt.is_mark) begin
      launch_nxt.ok   = (first_pos != '0) && (first_pos <= eff_size);
      launch_nxt.p_lo = first_pos - PW'(1);
    end else begin
      launch_nxt.ok   = (first_pos != '0) && (first_pos <= last_pos) && (last_pos <= eff_size);
      launch_nxt.p_hi = last_pos;
      launch_nxt.p_lo = first_pos - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r.active <= 1'b0;
    end else begin
      launch_r.active <= launch_nxt.active;
    end
    launch_r.is_mark <= launch_nxt.is_mark;
    launch_r.ok      <= launch_nxt.ok;
    launch_r.fresh   <= launch_nxt.fresh;
    launch_r.p_hi    <= launch_nxt.p_hi;
    launch_r.p_lo    <= launch_nxt.p_lo;
    launch_r.sum_hi  <= launch_nxt.sum_hi;
    launch_r.sum_lo  <= launch_nxt.sum_lo;
  end

  // Row of level cells, leaves first.
  assign chain[0] = launch_r;
  for (genvar g = 0; g < NL; g++) begin : g_lvl
    mprc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .level    (mprc_pkg::LVL_W'(g)),
      .clr_en   (clr_r),
      .clr_addr (clr_cnt_r),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end

  // A finished query leaves the top cell and waits until the output is free; a mark does not wait.
  assign release_c = done_r.active && (done_r.is_mark || !out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      done_r.active <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (release_c) begin
        busy_r <= 1'b0;
      end
      if (chain[NL].active) begin
        done_r.active <= 1'b1;
      end else if (release_c) begin
        done_r.active <= 1'b0;
      end
      if (release_c && !done_r.is_mark) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (chain[NL].active) begin
      done_r.is_mark <= chain[NL].is_mark;
      done_r.ok      <= chain[NL].ok;
      done_r.fresh   <= chain[NL].fresh;
      done_r.p_hi    <= chain[NL].p_hi;
      done_r.p_lo    <= chain[NL].p_lo;
      done_r.sum_hi  <= chain[NL].sum_hi;
      done_r.sum_lo  <= chain[NL].sum_lo;
    end
    if (release_c && !done_r.is_mark) begin
      out_cnt_r <= done_r.ok ? (done_r.sum_hi - done_r.sum_lo) : '0;
      out_err_r <= !done_r.ok;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {5'd0, out_cnt_r};
  assign out_tuser[0] = out_err_r;

endmodule
`default_nettype wire
